@@ hdl/dsu_pkg.sv @@
// shared constants for the disjoint-set engine
`default_nettype none

package dsu_pkg;

    // default node count of the engine
    localparam int NODES_DEF = 32768;

    // fixed field widths of the transaction ports
    localparam int NODE_W = 15;
    localparam int SIZE_W = 16;

    // rank field of a stored entry, saturating at its top value
    localparam int RANK_W = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    // index reduction: bits folded in per cycle and steps per index
    localparam int MOD_STEP_BITS = 5;
    localparam int MOD_STEPS = (NODE_W + MOD_STEP_BITS - 1) / MOD_STEP_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

endpackage

`default_nettype wire

@@ hdl/dsu_node_mod.sv @@
// reduces a raw node index modulo the node count, MOD_STEP_BITS bits per cycle
`default_nettype none

module dsu_node_mod #(
    parameter int NODES = dsu_pkg::NODES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [dsu_pkg::NODE_W-1:0]       raw,
    output logic                                  idle,
    output logic [$clog2(NODES)-1:0]              idx
);
    import dsu_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam logic [IW:0] NODES_X = (IW+1)'(NODES);

    logic                 busy_reg;
    logic                 busy_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_CNT_W-1:0] cnt_next;
    logic [IW-1:0]        rem_reg;
    logic [IW-1:0]        rem_next;
    logic [NODE_W-1:0]    shf_reg;
    logic [NODE_W-1:0]    shf_next;
    logic [IW:0]          r;
    logic [NODE_W-1:0]    sh;

    // restoring remainder: per bit, shift it in and subtract the node count at most once
    always_comb
    begin
        r = {1'b0, rem_reg};
        sh = shf_reg;
        for (int k = 0; k < MOD_STEP_BITS; k++)
        begin
            r = {r[IW-1:0], sh[NODE_W-1]};
            if (r >= NODES_X)
            begin
                r = r - NODES_X;
            end
            sh = {sh[NODE_W-2:0], 1'b0};
        end
    end

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            shf_next  = raw;
        end
        else if (busy_reg)
        begin
            rem_next = r[IW-1:0];
            shf_next = sh;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // remainder and pending bits
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
    end

    assign idle = !busy_reg;
    assign idx  = rem_reg;

endmodule

`default_nettype wire

@@ hdl/dsu_store.sv @@
// node entry memory: one write port, one registered read port
`default_nettype none

module dsu_store #(
    parameter int DEPTH  = dsu_pkg::NODES_DEF,
    parameter int DATA_W = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]             rd_data
);
    import dsu_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/disjoint_set_union_find.sv @@
// Disjoint-set (union-find) engine with union by rank and path compression.
// Every node keeps one entry {parent, rank, size} in a single synchronous memory
// with one write and one read port. After reset the engine runs a clearing pass
// (every node becomes a singleton) and accepts no transaction until it ends.
// A transaction is accepted in the idle state and both node indices are reduced
// modulo NODES. Each of the two finds then reads along the parent chain to the
// root and, when the start node is not the root, makes a second pass from the
// start node that points every node on the path below the root at the root.
// After that the engine decides; a real merge then writes the linked root and
// the surviving root, and the result register loads, waiting on a full one.
// The memory read loop along the parent chain bounds the time. One transaction
// is in flight at a time; a finished result sits in the output register while
// the next transaction is accepted.
`default_nettype none

module disjoint_set_union_find #(
    parameter int NODES = dsu_pkg::NODES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        opcode,
    input  wire logic [dsu_pkg::NODE_W-1:0]  node_a,
    input  wire logic [dsu_pkg::NODE_W-1:0]  node_b,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [dsu_pkg::NODE_W-1:0]       root_a,
    output logic [dsu_pkg::SIZE_W-1:0]       set_size,
    output logic                             same_set,
    output logic                             merged,
    output logic [dsu_pkg::SIZE_W-1:0]       set_count
);
    import dsu_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int DW = IW + RANK_W + CW;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MOD      = 4'd2;
    localparam logic [3:0] S_WALK_RD  = 4'd3;
    localparam logic [3:0] S_WALK_CHK = 4'd4;
    localparam logic [3:0] S_CMP_CHK  = 4'd5;
    localparam logic [3:0] S_UPDATE   = 4'd6;
    localparam logic [3:0] S_LINK_HI  = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic              op_reg, op_next;
    logic [IW-1:0]     a_reg, a_next;
    logic [IW-1:0]     b_reg, b_next;
    logic              which_reg, which_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     ra_reg, ra_next;
    logic [RANK_W-1:0] ra_rank_reg, ra_rank_next;
    logic [CW-1:0]     ra_cnt_reg, ra_cnt_next;
    logic [IW-1:0]     rb_reg, rb_next;
    logic [RANK_W-1:0] rb_rank_reg, rb_rank_next;
    logic [CW-1:0]     rb_cnt_reg, rb_cnt_next;
    logic              same_reg, same_next;
    logic              merge_reg, merge_next;
    logic [CW-1:0]     sets_reg, sets_next;

    logic              out_valid_reg;
    logic [NODE_W-1:0] out_root_reg;
    logic [SIZE_W-1:0] out_size_reg;
    logic              out_same_reg;
    logic              out_merge_reg;
    logic [SIZE_W-1:0] out_count_reg;
    logic              out_load;

    logic              mod_start;
    logic              mod_idle_a, mod_idle_b;
    logic [IW-1:0]     mod_idx_a, mod_idx_b;

    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    logic [DW-1:0]     mem_wr_data;
    logic              mem_rd_en;
    logic [IW-1:0]     mem_rd_addr;
    logic [DW-1:0]     mem_rd_data;
    logic [IW-1:0]     rd_parent;
    logic [RANK_W-1:0] rd_rank;
    logic [CW-1:0]     rd_cnt;

    logic [IW-1:0]     start_node;
    logic [IW-1:0]     find_root;
    logic              swap;
    logic [IW-1:0]     lo_node, hi_node;
    logic [RANK_W-1:0] lo_rank, hi_rank;
    logic [CW-1:0]     lo_cnt, hi_cnt;

    // index reduction units
    dsu_node_mod #(
        .NODES (NODES)
    ) u_mod_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .raw   (node_a),
        .idle  (mod_idle_a),
        .idx   (mod_idx_a)
    );

    dsu_node_mod #(
        .NODES (NODES)
    ) u_mod_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .raw   (node_b),
        .idle  (mod_idle_b),
        .idx   (mod_idx_b)
    );

    // node entry memory
    dsu_store #(
        .DEPTH  (NODES),
        .DATA_W (DW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // entry fields
    assign rd_parent = mem_rd_data[DW-1 -: IW];
    assign rd_rank   = mem_rd_data[CW +: RANK_W];
    assign rd_cnt    = mem_rd_data[CW-1:0];

    // helpers for the current find and the link decision
    assign start_node = which_reg ? b_reg : a_reg;
    assign find_root  = which_reg ? rb_reg : ra_reg;
    assign swap       = ra_rank_reg > rb_rank_reg;
    assign lo_node    = swap ? rb_reg : ra_reg;
    assign hi_node    = swap ? ra_reg : rb_reg;
    assign lo_rank    = swap ? rb_rank_reg : ra_rank_reg;
    assign hi_rank    = swap ? ra_rank_reg : rb_rank_reg;
    assign lo_cnt     = swap ? rb_cnt_reg : ra_cnt_reg;
    assign hi_cnt     = swap ? ra_cnt_reg : rb_cnt_reg;

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        which_next   = which_reg;
        cur_next     = cur_reg;
        ra_next      = ra_reg;
        ra_rank_next = ra_rank_reg;
        ra_cnt_next  = ra_cnt_reg;
        rb_next      = rb_reg;
        rb_rank_next = rb_rank_reg;
        rb_cnt_next  = rb_cnt_reg;
        same_next    = same_reg;
        merge_next   = merge_reg;
        sets_next    = sets_reg;
        mod_start    = 1'b0;
        in_ready     = 1'b0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = cur_reg;
        mem_wr_data  = mem_rd_data;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = cur_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // every node starts as its own singleton root
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = {clr_reg, RANK_W'(0), CW'(1)};
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == IW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = opcode;
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
            end

            S_MOD:
            begin
                if (mod_idle_a && mod_idle_b)
                begin
                    a_next     = mod_idx_a;
                    b_next     = mod_idx_b;
                    cur_next   = mod_idx_a;
                    which_next = 1'b0;
                    state_next = S_WALK_RD;
                end
            end

            S_WALK_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cur_reg;
                state_next  = S_WALK_CHK;
            end

            S_WALK_CHK:
            begin
                if (rd_parent == cur_reg)
                begin
                    // root reached: keep its rank and size
                    if (which_reg)
                    begin
                        rb_next      = cur_reg;
                        rb_rank_next = rd_rank;
                        rb_cnt_next  = rd_cnt;
                    end
                    else
                    begin
                        ra_next      = cur_reg;
                        ra_rank_next = rd_rank;
                        ra_cnt_next  = rd_cnt;
                    end
                    if (start_node == cur_reg)
                    begin
                        if (which_reg)
                        begin
                            state_next = S_UPDATE;
                        end
                        else
                        begin
                            which_next = 1'b1;
                            cur_next   = b_reg;
                            state_next = S_WALK_RD;
                        end
                    end
                    else
                    begin
                        // second pass from the start node
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = start_node;
                        cur_next    = start_node;
                        state_next  = S_CMP_CHK;
                    end
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rd_parent;
                    cur_next    = rd_parent;
                end
            end

            S_CMP_CHK:
            begin
                // point the visited node straight at the root
                mem_wr_en   = 1'b1;
                mem_wr_addr = cur_reg;
                mem_wr_data = {find_root, rd_rank, rd_cnt};
                if (rd_parent == find_root)
                begin
                    // the next find reads in the cycle after this write
                    if (which_reg)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        which_next = 1'b1;
                        cur_next   = b_reg;
                        state_next = S_WALK_RD;
                    end
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rd_parent;
                    cur_next    = rd_parent;
                end
            end

            S_UPDATE:
            begin
                same_next = (ra_reg == rb_reg);
                if (!op_reg && (ra_reg != rb_reg))
                begin
                    // link lower rank root under the other
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = lo_node;
                    mem_wr_data = {hi_node, lo_rank, lo_cnt};
                    ra_next     = hi_node;
                    if ((lo_rank == hi_rank) && (hi_rank < RANK_MAX))
                    begin
                        ra_rank_next = hi_rank + 1'b1;
                    end
                    else
                    begin
                        ra_rank_next = hi_rank;
                    end
                    ra_cnt_next = hi_cnt + lo_cnt;
                    if (sets_reg != '0)
                    begin
                        sets_next = sets_reg - 1'b1;
                    end
                    merge_next = 1'b1;
                    state_next = S_LINK_HI;
                end
                else
                begin
                    merge_next = 1'b0;
                    state_next = S_OUT;
                end
            end

            S_LINK_HI:
            begin
                // new rank and size of the surviving root
                mem_wr_en   = 1'b1;
                mem_wr_addr = ra_reg;
                mem_wr_data = {ra_reg, ra_rank_reg, ra_cnt_reg};
                state_next  = S_OUT;
            end

            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            sets_reg  <= CW'(NODES);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sets_reg  <= sets_next;
        end
    end

    // transaction working registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        which_reg   <= which_next;
        cur_reg     <= cur_next;
        ra_reg      <= ra_next;
        ra_rank_reg <= ra_rank_next;
        ra_cnt_reg  <= ra_cnt_next;
        rb_reg      <= rb_next;
        rb_rank_reg <= rb_rank_next;
        rb_cnt_reg  <= rb_cnt_next;
        same_reg    <= same_next;
        merge_reg   <= merge_next;
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_root_reg  <= NODE_W'(ra_reg);
            out_size_reg  <= SIZE_W'(ra_cnt_reg);
            out_same_reg  <= same_reg;
            out_merge_reg <= merge_reg;
            out_count_reg <= SIZE_W'(sets_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign root_a    = out_root_reg;
    assign set_size  = out_size_reg;
    assign same_set  = out_same_reg;
    assign merged    = out_merge_reg;
    assign set_count = out_count_reg;

    // no read and write of the same entry in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("memory read and write collide on one entry");

    // at least one set always remains
    assert property (@(posedge clk) disable iff (!rst_n)
        sets_reg != '0)
        else $error("set count reached zero");

    // a real merge never reports both nodes in one set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(merged && same_set))
        else $error("merged result flagged as same set");

endmodule

`default_nettype wire

@@ verif/dsu_result_checker.sv @@
// opcode names and the result checker for the disjoint-set engine
`timescale 1ns / 1ps

package dsu_test_pkg;

    // transaction opcodes
    typedef enum logic {
        OP_UNION = 1'b0,
        OP_QUERY = 1'b1
    } dsu_op_t;

endpackage

module dsu_result_checker #(
    parameter int NODES = dsu_pkg::NODES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       opcode,
    input  logic [dsu_pkg::NODE_W-1:0] node_a,
    input  logic [dsu_pkg::NODE_W-1:0] node_b,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [dsu_pkg::NODE_W-1:0] root_a,
    input  logic [dsu_pkg::SIZE_W-1:0] set_size,
    input  logic                       same_set,
    input  logic                       merged,
    input  logic [dsu_pkg::SIZE_W-1:0] set_count,
    output int                         failures,
    output int                         pending
);
    import dsu_pkg::*;
    import dsu_test_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0] root;
        logic [SIZE_W-1:0] size;
        logic              same;
        logic              merged;
        logic [SIZE_W-1:0] count;
    } dsu_result_t;

    // shadow copy of the forest, counts kept at full size
    int unsigned       parent_of [NODES];
    logic [RANK_W-1:0] rank_of   [NODES];
    int unsigned       members_of[NODES];
    int unsigned       sets_remaining;

    dsu_result_t expected_results[$];
    int          fail_total = 0;

    // walk up to the root, then point every visited node at it
    function automatic int unsigned find_root(input int unsigned start);
        int unsigned r;
        int unsigned n;
        int unsigned nxt;
        int unsigned steps;
        r = start;
        steps = 0;
        while (parent_of[r] != r && steps < NODES)
        begin
            r = parent_of[r] % NODES;
            steps++;
        end
        n = start;
        steps = 0;
        while (n != r && steps < NODES)
        begin
            nxt = parent_of[n] % NODES;
            parent_of[n] = r;
            n = nxt;
            steps++;
        end
        return r;
    endfunction

    // apply one transaction to the shadow forest and return its result
    function automatic dsu_result_t predict_union_find(input logic op,
                                                       input logic [NODE_W-1:0] a_in,
                                                       input logic [NODE_W-1:0] b_in);
        dsu_result_t res;
        int unsigned ra;
        int unsigned rb;
        int unsigned lo;
        int unsigned hi;
        logic        same;
        ra = find_root(int'(a_in) % NODES);
        rb = find_root(int'(b_in) % NODES);
        same = (ra == rb);
        res.merged = 1'b0;
        if (op == OP_UNION && !same)
        begin
            // lower rank goes under the other root, second root wins a tie
            lo = ra;
            hi = rb;
            if (rank_of[lo] > rank_of[hi])
            begin
                lo = rb;
                hi = ra;
            end
            parent_of[lo] = hi;
            if (rank_of[lo] == rank_of[hi] && rank_of[hi] < RANK_MAX)
                rank_of[hi] = rank_of[hi] + 1'b1;
            members_of[hi] = members_of[hi] + members_of[lo];
            if (sets_remaining > 0)
                sets_remaining--;
            res.merged = 1'b1;
            ra = hi;
        end
        res.root  = ra[NODE_W-1:0];
        res.size  = members_of[ra][SIZE_W-1:0];
        res.same  = same;
        res.count = sets_remaining[SIZE_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_total++;
            if (fail_total <= 10)
                $display("%0t mismatch %s: expected %0d, actual %0d",
                         $realtime, name, want, got);
        end
    endtask

    // track both channels: results are compared before new transactions are queued
    always @(posedge clk or negedge rst_n)
    begin
        dsu_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                parent_of[i]  = i;
                rank_of[i]    = '0;
                members_of[i] = 1;
            end
            sets_remaining = NODES;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t unexpected result root_a %0d with nothing pending",
                                 $realtime, root_a);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("root_a", want.root, root_a);
                    check_field("set_size", want.size, set_size);
                    check_field("same_set", want.same, same_set);
                    check_field("merged", want.merged, merged);
                    check_field("set_count", want.count, set_count);
                end
            end
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(),
                                        predict_union_find(opcode, node_a, node_b));
            pending  <= expected_results.size();
            failures <= fail_total;
        end
    end

endmodule

@@ verif/disjoint_set_union_find_test.sv @@
// stimulus and verdict for the disjoint-set engine
`timescale 1ns / 1ps

module disjoint_set_union_find_test;
    import dsu_pkg::*;
    import dsu_test_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              opcode    = 1'b0;
    logic [NODE_W-1:0] node_a    = '0;
    logic [NODE_W-1:0] node_b    = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [NODE_W-1:0] root_a;
    logic [SIZE_W-1:0] set_size;
    logic              same_set;
    logic              merged;
    logic [SIZE_W-1:0] set_count;

    int failures;
    int pending;
    int burst_left     = 0;
    int accepted_items = 0;

    always #6 clk = ~clk;

    disjoint_set_union_find dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .root_a    (root_a),
        .set_size  (set_size),
        .same_set  (same_set),
        .merged    (merged),
        .set_count (set_count)
    );

    dsu_result_checker result_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .root_a    (root_a),
        .set_size  (set_size),
        .same_set  (same_set),
        .merged    (merged),
        .set_count (set_count),
        .failures  (failures),
        .pending   (pending)
    );

    // offer one transaction, first drawing a new burst and a random idle gap, possibly empty, when the burst is used up
    task automatic offer_transaction(input dsu_op_t op, input int unsigned a,
                                     input int unsigned b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        node_a   <= a[NODE_W-1:0];
        node_b   <= b[NODE_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        accepted_items++;
    endtask

    // pick a node, mostly from a small neighborhood so that sets grow deep
    function automatic int unsigned pick_node(input int unsigned base);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 32767);
        return base + $urandom_range(0, 63);
    endfunction

    // stimulus
    initial
    begin
        int unsigned base;
        dsu_op_t     op;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // singletons, self union, extremes of the index range
        offer_transaction(OP_QUERY, 0, 32767);
        offer_transaction(OP_UNION, 0, 0);
        offer_transaction(OP_UNION, 0, 32767);
        offer_transaction(OP_QUERY, 32767, 0);
        offer_transaction(OP_UNION, 32767, 0);
        // equal ranks, lower rank first, higher rank first
        offer_transaction(OP_UNION, 1, 2);
        offer_transaction(OP_UNION, 2, 0);
        offer_transaction(OP_UNION, 3, 1);
        offer_transaction(OP_UNION, 32767, 4);
        offer_transaction(OP_QUERY, 4, 1);
        // alternating bit patterns
        offer_transaction(OP_UNION, 16383, 21845);
        offer_transaction(OP_UNION, 10922, 16384);
        offer_transaction(OP_QUERY, 21845, 10922);
        offer_transaction(OP_UNION, 16383, 10922);
        // balanced tree of eight nodes, then a merge of unequal ranks
        for (int i = 0; i < 4; i++)
            offer_transaction(OP_UNION, 100 + 2 * i, 101 + 2 * i);
        offer_transaction(OP_UNION, 100, 102);
        offer_transaction(OP_UNION, 104, 106);
        offer_transaction(OP_UNION, 100, 104);
        offer_transaction(OP_QUERY, 100, 107);
        offer_transaction(OP_UNION, 107, 0);

        // random part: neighborhoods move now and then
        base = 0;
        for (int i = 0; i < 600; i++)
        begin
            if (i % 75 == 0)
                base = $urandom_range(0, 32767 - 63);
            op = ($urandom_range(0, 9) < 6) ? OP_UNION : OP_QUERY;
            offer_transaction(op, pick_node(base), pick_node(base));
        end
        in_valid <= 1'b0;

        // drain, then allow for any stray result
        do
            @(posedge clk);
        while (pending != 0);
        repeat (100) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver: mixed stall pattern with one long hold-off mid-run
    initial
    begin
        int unsigned mode;
        int unsigned span;
        bit          held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && accepted_items >= 200)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(1, 24);
            repeat (span)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 2) != 0);
                    2:       out_ready <= ($urandom_range(0, 1) != 0);
                    default: out_ready <= 1'b0;
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog
    initial
    begin
        #(6_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/dsu_pkg.sv
hdl/dsu_node_mod.sv
hdl/dsu_store.sv
hdl/disjoint_set_union_find.sv
verif/dsu_result_checker.sv
verif/disjoint_set_union_find_test.sv
